// ----- rtl/eusf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eusf_pkg
// Shared widths, register indexes and types of the encoder unwrap and speed
// filter.
// ----------------------------------------------------------------------------
package eusf_pkg;

    localparam int ANGLE_BITS = 14;
    localparam int FRAME_BITS = 24;

    localparam int DELTA_W = ANGLE_BITS + 1;
    localparam int POS_W   = 32;
    localparam int SCALE_W = 16;
    localparam int THR_W   = 27;
    localparam int GAIN_W  = 16;
    localparam int SPEED_W = 32;
    localparam int FRAC_SH = 16;

    // signed delta times unsigned scale
    localparam int TGT_W  = DELTA_W + SCALE_W + 1;
    localparam int DIFF_W = ((TGT_W > SPEED_W) ? TGT_W : SPEED_W) + 1;
    localparam int PROD_W = DIFF_W + GAIN_W + 1;
    localparam int SHR_W  = PROD_W - FRAC_SH;
    localparam int SUM_W  = SHR_W + 1;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam int IN_W      = FRAME_BITS;
    localparam int OUT_BITS  = ANGLE_BITS + 2 * POS_W + SPEED_W;
    localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

    localparam logic signed [DELTA_W-1:0] HALF_TURN =
        DELTA_W'(1 << (ANGLE_BITS - 1));
    localparam logic signed [DELTA_W:0]   FULL_TURN =
        (DELTA_W + 1)'(1 << ANGLE_BITS);

    localparam logic signed [SUM_W-1:0] SPEED_MAX =
        SUM_W'((64'sd1 <<< (SPEED_W - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] SPEED_MIN =
        SUM_W'(-(64'sd1 <<< (SPEED_W - 1)));

    localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_JUMP_THRESHOLD = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_NORMAL    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_JUMP      = CFG_IDX_W'(3);

    localparam logic [SCALE_W-1:0] RST_SPEED_SCALE    = SCALE_W'(9375);
    localparam logic [THR_W-1:0]   RST_JUMP_THRESHOLD = THR_W'(844800);
    localparam logic [GAIN_W-1:0]  RST_GAIN_NORMAL    = GAIN_W'(655);
    localparam logic [GAIN_W-1:0]  RST_GAIN_JUMP      = GAIN_W'(66);

    typedef struct packed {
        logic [SCALE_W-1:0] speed_scale;
        logic [THR_W-1:0]   jump_threshold;
        logic [GAIN_W-1:0]  gain_normal;
        logic [GAIN_W-1:0]  gain_jump;
    } t_cfg;

    // one unwrapped sample, waiting for the speed filter
    typedef struct packed {
        logic [ANGLE_BITS-1:0]    angle;
        logic [POS_W-1:0]         total;
        logic [POS_W-1:0]         turns;
        logic signed [DELTA_W-1:0] delta;
        logic                     update;
    } t_job;

endpackage
`default_nettype wire

// ----- rtl/encoder_unwrap_speed_filter.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// encoder_unwrap_speed_filter
// Multi-turn unwrap and filtered speed estimate for an absolute angle encoder.
// ----------------------------------------------------------------------------
// One result per accepted frame, in order. The front end takes a frame in the
// cycle it arrives and unwraps it at once into a two-entry queue; the speed
// filter behind it works on one sample at a time (scale multiply, gain
// compare, gain multiply, add and saturate) and takes the next from the queue
// as it hands a result on, with up to four samples held between input and
// output. The first frame after reset only sets the reference angle and
// reports zero position, turns and speed. Registers are written over the
// config channel, which is always ready, and are read by the filter as it
// works on each sample; indexes beyond the four registers are ignored.
module encoder_unwrap_speed_filter import eusf_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // [23:0] raw_frame
    input  wire logic [IN_W-1:0]       i_s_axis_tdata,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // angle_count, total_count, turn_count, speed_q8 from bit 0 up, zero pad
    output logic [OUT_W-1:0]           o_m_axis_tdata,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg r_cfg;

    logic                  w_push;
    t_job                  w_push_job;
    logic                  w_q_ready;
    logic                  w_q_valid;
    t_job                  w_q_job;
    logic                  w_pop;
    logic [ANGLE_BITS-1:0] w_angle;
    logic [POS_W-1:0]      w_total;
    logic [POS_W-1:0]      w_turns;
    logic [SPEED_W-1:0]    w_speed;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed_scale    <= RST_SPEED_SCALE;
            r_cfg.jump_threshold <= RST_JUMP_THRESHOLD;
            r_cfg.gain_normal    <= RST_GAIN_NORMAL;
            r_cfg.gain_jump      <= RST_GAIN_JUMP;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SPEED_SCALE:    r_cfg.speed_scale    <= i_cfg_data[SCALE_W-1:0];
                REG_JUMP_THRESHOLD: r_cfg.jump_threshold <= i_cfg_data[THR_W-1:0];
                REG_GAIN_NORMAL:    r_cfg.gain_normal    <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_JUMP:      r_cfg.gain_jump      <= i_cfg_data[GAIN_W-1:0];
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    eusf_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .i_frame   (i_s_axis_tdata[FRAME_BITS-1:0]),
        .o_ready   (o_s_axis_tready),
        .i_q_ready (w_q_ready),
        .o_push    (w_push),
        .o_job     (w_push_job)
    );

    eusf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_job   (w_q_job)
    );

    eusf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (w_q_valid),
        .i_job     (w_q_job),
        .o_pop     (w_pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_angle   (w_angle),
        .o_total   (w_total),
        .o_turns   (w_turns),
        .o_speed   (w_speed)
    );

    assign o_m_axis_tdata = {{(OUT_W-OUT_BITS){1'b0}}, w_speed, w_turns, w_total, w_angle};

endmodule
`default_nettype wire

// ----- rtl/eusf_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eusf_front
// Takes encoder frames, unwraps the angle into a multi-turn position and
// turn count, and hands the sample delta to the queue.
// ----------------------------------------------------------------------------
module eusf_front import eusf_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic [FRAME_BITS-1:0] i_frame,
    output logic                       o_ready,
    input  wire logic                  i_q_ready,
    output logic                       o_push,
    output t_job                       o_job
);

    logic [ANGLE_BITS-1:0] r_prev;
    logic                  r_primed;
    logic [POS_W-1:0]      r_total;
    logic [POS_W-1:0]      r_turns;

    logic [ANGLE_BITS-1:0]      w_angle;
    logic signed [DELTA_W-1:0]  w_pd;
    logic signed [DELTA_W-1:0]  w_cd;
    logic signed [DELTA_W:0]    w_pd_x;
    logic signed [DELTA_W:0]    w_cd_x;
    logic signed [DELTA_W-1:0]  w_delta;
    logic [POS_W-1:0]           n_total;
    logic [POS_W-1:0]           n_turns;

    assign w_angle = i_frame[FRAME_BITS-1 -: ANGLE_BITS];
    assign w_pd    = $signed({1'b0, r_prev}) - $signed({1'b0, w_angle});
    assign w_cd    = -w_pd;
    assign w_pd_x  = {w_pd[DELTA_W-1], w_pd};
    assign w_cd_x  = {w_cd[DELTA_W-1], w_cd};

    always_comb begin
        n_turns = r_turns;
        priority if (w_pd >= HALF_TURN) begin
            // forward crossing of zero
            w_delta = DELTA_W'(FULL_TURN - w_pd_x);
            n_turns = r_turns + POS_W'(1);
        end else if (w_cd >= HALF_TURN) begin
            w_delta = DELTA_W'(w_cd_x - FULL_TURN);
            n_turns = r_turns - POS_W'(1);
        end else begin
            w_delta = w_cd;
        end
        n_total = r_total + {{(POS_W-DELTA_W){w_delta[DELTA_W-1]}}, w_delta};
    end

    assign o_ready = i_q_ready;
    assign o_push  = i_valid && i_q_ready;

    always_comb begin
        o_job.angle  = w_angle;
        o_job.update = r_primed;
        if (r_primed) begin
            o_job.total = n_total;
            o_job.turns = n_turns;
            o_job.delta = w_delta;
        end else begin
            o_job.total = r_total;
            o_job.turns = r_turns;
            o_job.delta = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= '0;
            r_primed <= 1'b0;
            r_total  <= '0;
            r_turns  <= '0;
        end else if (o_push) begin
            r_prev   <= w_angle;
            r_primed <= 1'b1;
            r_total  <= o_job.total;
            r_turns  <= o_job.turns;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/eusf_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eusf_queue
// Two-entry queue of unwrapped samples between the front and the filter.
// ----------------------------------------------------------------------------
module eusf_queue import eusf_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_ready,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_job      o_job
);

    logic [1:0] r_count;
    t_job       r_head;
    t_job       r_tail;

    logic       w_to_head;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_head;

    // land in the head when it is free or drains this cycle
    assign w_to_head = i_push && (r_count == 2'd0 || (r_count == 2'd1 && i_pop));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_to_head) begin
            r_head <= i_job;
        end else if (i_pop) begin
            r_head <= r_tail;
        end
        if (i_push && !w_to_head) begin
            r_tail <= i_job;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/eusf_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eusf_back
// Speed filter: scales the sample delta to Q8 rpm, picks the filter gain and
// updates the first-order low-pass, then presents the result.
// ----------------------------------------------------------------------------
module eusf_back import eusf_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cfg             i_cfg,
    input  wire logic             i_q_valid,
    input  wire t_job             i_job,
    output logic                  o_pop,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [ANGLE_BITS-1:0] o_angle,
    output logic [POS_W-1:0]      o_total,
    output logic [POS_W-1:0]      o_turns,
    output logic [SPEED_W-1:0]    o_speed
);

    typedef enum logic [2:0] {S_IDLE, S_MUL1, S_CMP, S_MUL2, S_DONE} t_state;

    t_state                     r_state;
    t_job                       r_job;
    logic signed [SPEED_W-1:0]  r_filtered;
    logic signed [TGT_W-1:0]    r_target;
    logic signed [DIFF_W-1:0]   r_diff;
    logic [GAIN_W-1:0]          r_gain;
    logic signed [PROD_W-1:0]   r_prod;
    logic                       r_out_valid;
    logic [ANGLE_BITS-1:0]      r_angle;
    logic [POS_W-1:0]           r_total;
    logic [POS_W-1:0]           r_turns;
    logic [SPEED_W-1:0]         r_speed;

    logic signed [SCALE_W:0]    w_scale;
    logic signed [TGT_W-1:0]    w_target;
    logic signed [DIFF_W-1:0]   w_diff;
    logic signed [DIFF_W-1:0]   w_thr;
    logic                       w_jump;
    logic signed [GAIN_W:0]     w_gain;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [SHR_W-1:0]    w_shr;
    logic signed [SUM_W-1:0]    w_sum;
    logic signed [SPEED_W-1:0]  w_next;
    logic                       w_out_free;
    logic                       w_done;

    assign w_scale  = $signed({1'b0, i_cfg.speed_scale});
    assign w_target = TGT_W'(r_job.delta * w_scale);

    assign w_diff = $signed({{(DIFF_W-TGT_W){r_target[TGT_W-1]}}, r_target})
                  - $signed({{(DIFF_W-SPEED_W){r_filtered[SPEED_W-1]}}, r_filtered});
    assign w_thr  = $signed({{(DIFF_W-THR_W){1'b0}}, i_cfg.jump_threshold});
    assign w_jump = (w_diff > w_thr) || (w_diff < -w_thr);

    assign w_gain = $signed({1'b0, r_gain});
    assign w_prod = PROD_W'(r_diff * w_gain);

    // flooring shift: drop the fraction bits of the signed product
    assign w_shr = r_prod[PROD_W-1:FRAC_SH];
    assign w_sum = $signed({w_shr[SHR_W-1], w_shr})
                 + $signed({{(SUM_W-SPEED_W){r_filtered[SPEED_W-1]}}, r_filtered});

    always_comb begin
        priority if (!r_job.update) begin
            w_next = r_filtered;
        end else if (w_sum > SPEED_MAX) begin
            w_next = SPEED_MAX[SPEED_W-1:0];
        end else if (w_sum < SPEED_MIN) begin
            w_next = SPEED_MIN[SPEED_W-1:0];
        end else begin
            w_next = w_sum[SPEED_W-1:0];
        end
    end

    assign w_out_free = !r_out_valid || i_ready;
    assign w_done     = (r_state == S_DONE) && w_out_free;
    assign o_pop      = i_q_valid && ((r_state == S_IDLE) || w_done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_filtered  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready && !w_done) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_target <= w_target;
                    r_state  <= S_CMP;
                end
                S_CMP: begin
                    r_diff  <= w_diff;
                    r_gain  <= w_jump ? i_cfg.gain_jump : i_cfg.gain_normal;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_prod  <= w_prod;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // hold until the output register can take the result
                    if (w_out_free) begin
                        r_filtered  <= w_next;
                        r_out_valid <= 1'b1;
                        r_angle     <= r_job.angle;
                        r_total     <= r_job.total;
                        r_turns     <= r_job.turns;
                        r_speed     <= w_next;
                        r_state     <= i_q_valid ? S_MUL1 : S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (o_pop) begin
                r_job <= i_job;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_angle = r_angle;
    assign o_total = r_total;
    assign o_turns = r_turns;
    assign o_speed = r_speed;

endmodule
`default_nettype wire
